// ===== src/slot_address_allocator_defines.svh =====
// Assertion macros for the slot address allocator.
// Used by the top level; expects clk and rst in scope.
`ifndef SLOT_ADDRESS_ALLOCATOR_DEFINES_SVH
`define SLOT_ADDRESS_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, ignored while in reset
`define SAA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot allocator check failed");

// Next-cycle implication, ignored while in reset
`define SAA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot allocator sequencing check failed");

`endif

// ===== src/saa_pkg.sv =====
// Shared types and constants of the slot address allocator.
// No dependencies; imported by saa_ram and slot_address_allocator.
package saa_pkg;

  // Occupancy bitmap word geometry
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // Request modes
  typedef enum logic [1:0] {
    MODE_NEXT   = 2'd0,
    MODE_STATIC = 2'd1,
    MODE_FREE   = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_t;

  // Control sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  // Position of the lowest set bit of a bitmap word
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== src/slot_address_allocator.sv =====
// Slot address allocator: occupancy bitmap in a word RAM (32 slots a word).
// Static assign, free and lookup: read the slot's bitmap word, update it and register the result.
// Assign next: scan bitmap words from the next-slot pointer (one RAM read a cycle) until a free
//   slot is found. A new request is taken only back in IDLE, once the result is registered.
// Reset (synchronous): a clearing pass writes one bitmap word a cycle over the whole bitmap,
//   before the first request.
`include "slot_address_allocator_defines.svh"
module slot_address_allocator import saa_pkg::*; #(
  parameter int TABLE_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] address_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic        found,
  output logic [31:0] assigned_address
);

  localparam int WORDS     = (TABLE_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W     = WADDR_W + BIT_W;
  localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int LAST_BITS = TABLE_SLOTS - WORD_W * (WORDS - 1);
  localparam logic [WORD_W-1:0] LAST_MASK =
    WORD_W'((64'd1 << LAST_BITS) - 64'd1);

  state_t             state;
  logic [31:0]        base_low;
  logic [CNT_W-1:0]   used_count;
  logic [IDX_W-1:0]   next_slot;
  logic [WADDR_W-1:0] clr_addr;
  logic [WADDR_W-1:0] scan_word;
  logic [WORD_W-1:0]  start_mask;
  logic               first_pass;
  mode_t              mode_r;
  logic [BIT_W-1:0]   slot_bit;
  logic               range_ok;
  logic               hold_status;
  logic               hold_found;
  logic [31:0]        hold_addr;

  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic [31:0]        in_idx;
  logic [WADDR_W-1:0] scan_word_next;
  logic [WORD_W-1:0]  word_valid;
  logic [WORD_W-1:0]  cand;
  logic [BIT_W-1:0]   pick_bit;
  logic               full;
  logic               cur_bit;
  logic               done;
  logic               wr_en;
  logic [WORD_W-1:0]  wr_data;
  logic               res_status;
  logic               res_found;
  logic [31:0]        res_addr;
  logic               cnt_inc;
  logic               cnt_dec;
  logic               ptr_upd;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign out_load = (((state == ST_EXEC) && done) || (state == ST_HOLD)) && out_free;

  // Slot index: byte-wise modulo-256 difference of address and base
  assign in_idx = {address_low[31:24] - base_low[31:24],
                   address_low[23:16] - base_low[23:16],
                   address_low[15:8]  - base_low[15:8],
                   address_low[7:0]   - base_low[7:0]};

  // Bitmap word storage
  saa_ram #(.WIDTH(WORD_W), .ADDR_W(WADDR_W)) u_occ_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan helpers: wrap word pointer, mask padding slots of the last word
  assign scan_word_next = (scan_word == WADDR_W'(WORDS - 1)) ? '0 : scan_word + 1'b1;
  assign word_valid     = (scan_word == WADDR_W'(WORDS - 1)) ? LAST_MASK : '1;
  assign cand     = ~ram_rdata & word_valid & (first_pass ? start_mask : '1);
  assign pick_bit = lowest_set(cand);
  assign full     = (used_count == CNT_W'(TABLE_SLOTS));
  assign cur_bit  = ram_rdata[slot_bit];

  // Read-modify-write decision on the word just read
  always_comb begin
    done       = 1'b1;
    wr_en      = 1'b0;
    wr_data    = ram_rdata;
    res_status = 1'b1;
    res_found  = 1'b0;
    res_addr   = '0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    ptr_upd    = 1'b0;
    unique case (mode_r)
      MODE_NEXT: begin
        if (!full) begin
          if (cand != '0) begin
            wr_en      = 1'b1;
            wr_data    = ram_rdata | (WORD_W'(1) << pick_bit);
            res_status = 1'b0;
            res_addr   = base_low | 32'({scan_word, pick_bit});
            cnt_inc    = 1'b1;
            ptr_upd    = 1'b1;
          end else begin
            done = 1'b0;
          end
        end
      end
      MODE_STATIC: begin
        if (!full && range_ok) begin
          res_status = 1'b0;
          if (!cur_bit) begin
            wr_en   = 1'b1;
            wr_data = ram_rdata | (WORD_W'(1) << slot_bit);
            cnt_inc = 1'b1;
          end
        end
      end
      MODE_FREE: begin
        if ((used_count != '0) && range_ok && cur_bit) begin
          wr_en      = 1'b1;
          wr_data    = ram_rdata & ~(WORD_W'(1) << slot_bit);
          res_status = 1'b0;
          cnt_dec    = 1'b1;
        end
      end
      MODE_LOOKUP: begin
        res_status = 1'b0;
        res_found  = (used_count != '0) && range_ok && cur_bit;
      end
      default: ;
    endcase
  end

  // RAM port steering: clearing pass, then request words
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_word;
    ram_wdata = wr_data;
    ram_raddr = scan_word_next;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_EXEC) begin
      ram_we = wr_en;
    end
    if (state == ST_IDLE) begin
      ram_raddr = (mode_t'(mode) == MODE_NEXT) ? next_slot[IDX_W-1:BIT_W]
                                              : in_idx[IDX_W-1:BIT_W];
    end
  end

  // Base address register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_low <= '0;
    end else if (cfg_we) begin
      base_low <= cfg_data;
    end
  end

  // Sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      used_count <= '0;
      next_slot  <= '0;
      out_valid  <= 1'b0;
    end else begin
      // raise the result when loaded, drop it once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == WADDR_W'(WORDS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (done) begin
            if (cnt_inc) used_count <= used_count + 1'b1;
            if (cnt_dec) used_count <= used_count - 1'b1;
            if (ptr_upd) next_slot <= {scan_word, pick_bit};
            if (out_free) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // Request capture and scan pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= mode_t'(mode);
      range_ok   <= (in_idx < 32'(TABLE_SLOTS));
      first_pass <= 1'b1;
      if (mode_t'(mode) == MODE_NEXT) begin
        scan_word  <= next_slot[IDX_W-1:BIT_W];
        slot_bit   <= next_slot[BIT_W-1:0];
        start_mask <= '1 << next_slot[BIT_W-1:0];
      end else begin
        scan_word  <= in_idx[IDX_W-1:BIT_W];
        slot_bit   <= in_idx[BIT_W-1:0];
        start_mask <= '1;
      end
    end else if ((state == ST_EXEC) && !done) begin
      // advance to the next bitmap word
      scan_word  <= scan_word_next;
      first_pass <= 1'b0;
    end
  end

  // Result payload: load directly, or park while the output is still occupied
  always_ff @(posedge clk) begin
    if ((state == ST_EXEC) && done) begin
      hold_status <= res_status;
      hold_found  <= res_found;
      hold_addr   <= res_addr;
      if (out_free) begin
        status           <= res_status;
        found            <= res_found;
        assigned_address <= res_addr;
      end
    end else if ((state == ST_HOLD) && out_free) begin
      status           <= hold_status;
      found            <= hold_found;
      assigned_address <= hold_addr;
    end
  end

  // Checks
  `SAA_ASSERT_NOW(a_count_bound, 1'b1, used_count <= CNT_W'(TABLE_SLOTS))
  `SAA_ASSERT_NOW(a_ptr_bound, 1'b1, 32'(next_slot) < 32'(TABLE_SLOTS))
  `SAA_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state == ST_EXEC)
  `SAA_ASSERT_NOW(a_no_write_idle, state == ST_IDLE, !ram_we)
  `SAA_ASSERT_NOW(a_found_ok, out_valid && found, !status)

endmodule

// ===== src/saa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on saa_pkg only by house convention (no items used beyond import).
module saa_ram import saa_pkg::*; #(
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:(2**ADDR_W)-1];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== sim/slot_address_allocator_check.sv =====
`timescale 1ns / 100ps
// Scoreboard for the slot address allocator: mirrors the occupancy table and
// checks every result in order. Depends on saa_pkg for the request modes.
module slot_address_allocator_check import saa_pkg::*; #(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] address_low,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        status,
  input  logic        found,
  input  logic [31:0] assigned_address,
  output int          mismatches,
  output int          awaiting,
  output int          checked
);

  localparam int PTR_W = $clog2(SLOTS);

  typedef struct packed {
    logic        status;
    logic        found;
    logic [31:0] addr;
  } grant_t;

  // Shadow of the allocator state
  logic [SLOTS-1:0] occupied;
  logic [PTR_W-1:0] scan_start;
  int               used;
  logic [31:0]      base;
  grant_t           grants_q[$];
  int               mismatch_n;
  int               checked_n;

  // Byte-wise difference of address and base, no borrow between bytes
  function automatic logic [31:0] slot_of_address(input logic [31:0] a,
                                                  input logic [31:0] b);
    logic [31:0] d;
    for (int k = 0; k < 4; k++) d[8*k +: 8] = a[8*k +: 8] - b[8*k +: 8];
    return d;
  endfunction

  // Apply one request to the shadow table and return what the block must answer
  function automatic grant_t serve(input mode_t m, input logic [31:0] a);
    grant_t      g;
    logic [31:0] idx;
    int          p;
    g.status = 1'b1;
    g.found  = 1'b0;
    g.addr   = '0;
    idx = slot_of_address(a, base);
    case (m)
      MODE_NEXT: begin
        if (used < SLOTS) begin
          // next-fit: walk forward from the remembered slot to the first hole
          p = int'(scan_start);
          for (int n = 0; n < SLOTS && occupied[p]; n++) p = (p + 1) % SLOTS;
          if (!occupied[p]) begin
            occupied[p] = 1'b1;
            scan_start  = PTR_W'(p);
            used++;
            g.addr   = base | 32'(p);
            g.status = 1'b0;
          end
        end
      end
      MODE_STATIC: begin
        if (used < SLOTS && idx < SLOTS) begin
          if (!occupied[idx[PTR_W-1:0]]) begin
            occupied[idx[PTR_W-1:0]] = 1'b1;
            used++;
          end
          g.status = 1'b0;
        end
      end
      MODE_FREE: begin
        if (used != 0 && idx < SLOTS && occupied[idx[PTR_W-1:0]]) begin
          occupied[idx[PTR_W-1:0]] = 1'b0;
          used--;
          g.status = 1'b0;
        end
      end
      MODE_LOOKUP: begin
        g.status = 1'b0;
        g.found  = (used != 0 && idx < SLOTS && occupied[idx[PTR_W-1:0]]);
      end
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      // Clear the shadow along with the block
      occupied   = '0;
      scan_start = '0;
      used       = 0;
      base       = '0;
      mismatch_n = 0;
      checked_n  = 0;
      grants_q.delete();
    end else begin
      if (cfg_we) base = cfg_data;

      // Compare the departing result with the oldest request still open
      if (out_valid && out_ready) begin
        checked_n++;
        if (grants_q.size() == 0) begin
          $error("result with no request waiting: status %0d found %0d address %h",
                 status, found, assigned_address);
          mismatch_n++;
        end else begin
          want = grants_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatch_n++;
          end
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            mismatch_n++;
          end
          if (assigned_address !== want.addr) begin
            $error("assigned_address: expected %h, got %h", want.addr, assigned_address);
            mismatch_n++;
          end
        end
      end

      // Predict the answer to a newly accepted request
      if (in_valid && in_ready) grants_q.push_back(serve(mode_t'(mode), address_low));
    end
    awaiting   <= grants_q.size();
    mismatches <= mismatch_n;
    checked    <= checked_n;
  end

endmodule

// ===== sim/slot_address_allocator_test.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the slot address allocator: requests, base writes
// and result back-pressure. Depends on saa_pkg, the RTL and the scoreboard.
module slot_address_allocator_test;
  import saa_pkg::*;

  localparam int SLOTS       = 256;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_we      = 1'b0;
  logic [31:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [1:0]  mode        = MODE_NEXT;
  logic [31:0] address_low = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic        status;
  logic        found;
  logic [31:0] assigned_address;

  logic        calm        = 1'b0;
  int          stall_left  = 0;
  int          cycle_n     = 0;
  int          mismatches;
  int          awaiting;
  int          checked;
  logic [31:0] base_now    = '0;
  int          bases_used  = 1;
  int          sent_by_mode[4];

  slot_address_allocator #(.TABLE_SLOTS(SLOTS)) u_top (
    .clk, .rst, .cfg_we, .cfg_data,
    .in_valid, .in_ready, .mode, .address_low,
    .out_valid, .out_ready, .status, .found, .assigned_address
  );

  slot_address_allocator_check #(.SLOTS(SLOTS)) u_check (
    .clk, .rst, .cfg_we, .cfg_data,
    .in_valid, .in_ready, .mode, .address_low,
    .out_valid, .out_ready, .status, .found, .assigned_address,
    .mismatches, .awaiting, .checked
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side at random, except in calm stretches
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Address that maps to the given slot under the current base
  function automatic logic [31:0] addr_of_slot(input logic [31:0] idx);
    logic [31:0] a;
    for (int k = 0; k < 4; k++) a[8*k +: 8] = base_now[8*k +: 8] + idx[8*k +: 8];
    return a;
  endfunction

  function automatic logic [31:0] any_slot_addr();
    return addr_of_slot($urandom_range(0, SLOTS - 1));
  endfunction

  // Address whose slot index lies beyond the table
  function automatic logic [31:0] stray_addr();
    logic [31:0] idx;
    idx = $urandom;
    if (idx[31:8] == '0) idx[31:8] = 24'($urandom_range(1, 24'hFFFFFF));
    return addr_of_slot(idx);
  endfunction

  // Hold one request on the input until the block takes it
  task automatic send(input mode_t m, input logic [31:0] a);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    address_low <= a;
    sent_by_mode[int'(m)]++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_noise();
    send(mode_t'($urandom_range(0, 3)), $urandom_range(0, 1) ? stray_addr() : $urandom);
  endtask

  // Drop valid and wait until every open request has been answered
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic program_base(input logic [31:0] b);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    cfg_we   <= 1'b0;
    base_now = b;
    bases_used++;
  endtask

  // One stretch of traffic: fill the table, drain it, or mix everything
  task automatic run_phase(input phase_kind_t kind, input int n_items);
    int sweep;
    int roll;
    sweep = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      // switch between bursty and back-to-back traffic
      if (i % 48 == 0) calm <= ($urandom_range(0, 3) == 0);
      // hold the sender until everything has come back, once in a while
      if ($urandom_range(0, 199) == 0) wait_drained();
      if (roll >= 90) begin
        send_noise();
      end else begin
        case (kind)
          PH_FILL: begin
            if (roll < 70) send(MODE_NEXT, $urandom);
            else if (roll < 82) send(MODE_STATIC, any_slot_addr());
            else send(MODE_LOOKUP, any_slot_addr());
          end
          PH_DRAIN: begin
            if (roll < 75) begin
              send(MODE_FREE, addr_of_slot(sweep));
              sweep = (sweep + 1) % SLOTS;
            end else begin
              send(MODE_LOOKUP, any_slot_addr());
            end
          end
          default: begin
            send(mode_t'(roll % 4), (roll < 72) ? any_slot_addr() : stray_addr());
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset base
    send(MODE_LOOKUP, 32'h0000_0000);   // lookup on an empty table
    send(MODE_FREE,   32'h0000_0000);   // free on an empty table
    send(MODE_STATIC, 32'hFFFF_FFFF);   // static assign out of range
    send(MODE_NEXT,   32'h0000_0000);
    send(MODE_NEXT,   32'hFFFF_FFFF);   // pointer slot taken, scan onward
    send(MODE_STATIC, 32'h0000_00FF);
    send(MODE_STATIC, 32'h0000_00FF);   // already occupied
    send(MODE_LOOKUP, 32'h0000_00FF);
    send(MODE_LOOKUP, 32'h0000_0100);   // lookup out of range
    send(MODE_LOOKUP, 32'hFFFF_FFFF);
    send(MODE_FREE,   32'h8000_0000);   // free out of range
    send(MODE_FREE,   32'h0000_0005);   // free a clear slot
    send(MODE_FREE,   32'h0000_00FF);
    send(MODE_FREE,   32'h0000_0000);
    send(MODE_NEXT,   32'h5555_AAAA);
    send(MODE_LOOKUP, 32'h0000_0000);
    send(MODE_STATIC, 32'h0000_0000);
    send(MODE_FREE,   32'hFFFF_FF00);
    send(MODE_LOOKUP, 32'h0000_0001);
    send(MODE_NEXT,   32'hAAAA_5555);

    // Random traffic under several base settings, extremes included
    program_base(32'hFFFF_FFFF);
    run_phase(PH_FILL, 380);
    program_base(32'hFFFF_FF00);
    run_phase(PH_DRAIN, 380);
    program_base($urandom & 32'hFFFF_FF00);
    run_phase(PH_MIXED, 300);
    program_base($urandom);
    run_phase(PH_FILL, 380);
    program_base(32'h0000_0000);
    run_phase(PH_DRAIN, 380);
    run_phase(PH_MIXED, 200);

    // Let the last results drain, then give the verdict
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d assign_next, %0d assign_static, %0d free, %0d lookup requests",
             sent_by_mode[0], sent_by_mode[1], sent_by_mode[2], sent_by_mode[3]);
    $display("Compared %0d results over %0d base settings, table filled and drained twice",
             checked, bases_used);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
